>>> hdl/cell_key_order_parser_macros.svh
// Assertion macros of the cell key order parser RTL.
`ifndef CELL_KEY_ORDER_PARSER_MACROS_SVH
`define CELL_KEY_ORDER_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CKOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CKOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ckop_pkg.sv
// Types and constants of the cell key order parser.
`timescale 1ns / 1ps
`default_nettype none

package ckop_pkg;

  localparam logic [7:0]  CHAR_G       = 8'h47;
  localparam logic [7:0]  CHAR_C       = 8'h43;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_NINE    = 8'h39;
  localparam logic [7:0]  CHAR_LOW_A   = 8'h61;
  localparam logic [7:0]  CHAR_LOW_F   = 8'h66;
  localparam logic [4:0]  POS_MAX      = 5'd31;
  localparam logic [3:0]  LAST_DIGIT   = 4'd15;
  localparam logic [63:0] ALL_ONES     = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] VALID_LSB    = 64'h1555_5555_5555_5555;
  localparam logic [63:0] CELL_BEFORE  = 64'd1;

  // One input word: a key byte and its framing flags.
  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
    logic       empty_key;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [63:0] cell_id;
    logic        in_cell;
  } out_word_t;

  // Parse state carried from byte to byte.
  typedef struct packed {
    logic [4:0]  pos;
    logic [63:0] num;
    logic        in_range;
    logic        decided;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{pos: 5'd0, num: 64'd0, in_range: 1'b1,
                                           decided: 1'b0};

endpackage

`default_nettype wire

>>> hdl/cell_key_order_parser.sv
// Top level of the cell key order parser: input register, parse state, result register.
// A word passes from the input register through the parse stage into the result register.
// Throughput: one key byte per cycle, except while a full result register is held.
// A word that ends a key (last byte or empty key) gives exactly one result word.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parse
// state to its start values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "cell_key_order_parser_macros.svh"

module cell_key_order_parser import ckop_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  // Input register: holds one accepted word for the parse stage.
  logic         in_valid_q;
  in_word_t     in_word_q;

  // Parse state across the bytes of one key.
  parse_state_t state_q;
  parse_state_t state_d;

  // Result register.
  logic         out_valid_q;
  out_word_t    out_word_q;

  logic         emit;
  out_word_t    result;
  logic         proc;
  logic         in_take;

  // The parse stage runs whenever it holds a word and the result register
  // has room or is being emptied this cycle.
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  ckop_step u_step (
    .state_i  (state_q),
    .word_i   (in_word_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The input side only waits on a full result register that is held.
  `CKOP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o,
                   in_valid_q && out_valid_q && out_stall_i, "input stall without cause")

  // A word that ends a key leaves the parse state at its start values.
  `CKOP_ASSERT_NXT(a_key_restart, clk_i, rst_ni, proc && emit,
                   state_q.pos == 5'd0 && !state_q.decided && state_q.in_range,
                   "parse state not restarted after a key")

  // A decision is only ever reached after at least one byte was consumed.
  `CKOP_ASSERT_IMP(a_decided_pos, clk_i, rst_ni, state_q.decided,
                   state_q.pos != 5'd0, "decision without consumed byte")

endmodule

`default_nettype wire

>>> hdl/ckop_step.sv
// Per-byte next-state and result logic of the cell key order parser.
`timescale 1ns / 1ps
`default_nettype none

module ckop_step import ckop_pkg::*; (
  input  parse_state_t state_i,
  input  in_word_t     word_i,
  output parse_state_t state_o,
  output logic         emit_o,
  output out_word_t    result_o
);

  logic [7:0]   b;
  logic [4:0]   p;
  logic [3:0]   dig_idx;
  logic [3:0]   nib;
  logic [3:0]   digit;
  logic [5:0]   sh;
  logic [5:0]   up_sh;
  logic [63:0]  n_dig;
  logic [64:0]  up_sum;
  parse_state_t cons;
  logic         need_chk;
  logic [63:0]  chk_n;
  logic         chk_inside;
  logic [63:0]  sel_n;
  logic [63:0]  lsb;
  parse_state_t fin;

  assign b       = word_i.key_byte;
  assign p       = state_i.pos;
  assign dig_idx = 4'(p - 5'd2);
  assign nib     = ~dig_idx;
  assign sh      = {nib, 2'b00};
  // Shift that bumps the previous digit by one when a byte above 'f' arrives.
  assign up_sh   = {4'(nib + 4'd1), 2'b00};
  assign up_sum  = {1'b0, state_i.num} + (65'd1 << up_sh);

  always_comb begin
    digit = 4'd0;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      digit = b[3:0];
    end else begin
      digit = 4'(b - CHAR_LOW_A + 8'd10);
    end
  end

  // Digit positions below the current one are still zero, so OR places it.
  assign n_dig = state_i.num | (64'(digit) << sh);

  // Byte consumption.
  always_comb begin
    cons       = state_i;
    need_chk   = 1'b0;
    chk_n      = state_i.num;
    chk_inside = 1'b0;
    if (!state_i.decided) begin
      if (p < POS_MAX) begin
        cons.pos = p + 5'd1;
      end
      if (p == 5'd0 || p == 5'd1) begin
        if (b < ((p == 5'd0) ? CHAR_G : CHAR_C)) begin
          cons.num      = CELL_BEFORE;
          cons.in_range = 1'b0;
          cons.decided  = 1'b1;
        end else if (b > ((p == 5'd0) ? CHAR_G : CHAR_C)) begin
          cons.num      = ALL_ONES;
          cons.in_range = 1'b0;
          cons.decided  = 1'b1;
        end
      end else begin
        priority if ((b >= CHAR_ZERO && b <= CHAR_NINE) ||
                     (b >= CHAR_LOW_A && b <= CHAR_LOW_F)) begin
          cons.num = n_dig;
          if (dig_idx == LAST_DIGIT) begin
            need_chk   = 1'b1;
            chk_n      = n_dig;
            chk_inside = state_i.in_range;
          end
        end else if (b < CHAR_ZERO) begin
          need_chk = 1'b1;
          chk_n    = state_i.num;
        end else if (b > CHAR_LOW_F) begin
          if (dig_idx == 4'd0 || up_sum[64]) begin
            cons.num      = ALL_ONES;
            cons.in_range = 1'b0;
            cons.decided  = 1'b1;
          end else begin
            need_chk = 1'b1;
            chk_n    = up_sum[63:0];
          end
        end else begin
          // Between '9' and 'a': round up to the next digit value of ten.
          need_chk = 1'b1;
          chk_n    = state_i.num | (64'd10 << sh);
        end
      end
    end
  end

  // Number under check: from consumption, or the accumulated number at close.
  assign sel_n = need_chk ? chk_n : cons.num;

  // Close of the key, then the final check of a finished number.
  always_comb begin
    fin = cons;
    lsb = 64'd0;
    if (word_i.last_byte && !cons.decided && !need_chk && cons.pos < 5'd2) begin
      fin.num      = CELL_BEFORE;
      fin.in_range = 1'b0;
      fin.decided  = 1'b1;
    end else if (need_chk || (word_i.last_byte && !cons.decided)) begin
      fin.decided = 1'b1;
      if (sel_n[63] && sel_n[62]) begin
        fin.num      = ALL_ONES;
        fin.in_range = 1'b0;
      end else begin
        lsb          = sel_n & (~sel_n + 64'd1);
        fin.num      = sel_n;
        fin.in_range = need_chk ? chk_inside : 1'b0;
        if ((lsb & VALID_LSB) == 64'd0) begin
          fin.num      = sel_n | 64'd1;
          fin.in_range = 1'b0;
        end
      end
    end
  end

  always_comb begin
    emit_o   = word_i.empty_key || word_i.last_byte;
    result_o = '{cell_id: fin.num, in_cell: fin.in_range};
    if (word_i.empty_key) begin
      result_o = '{cell_id: CELL_BEFORE, in_cell: 1'b0};
    end
    state_o = emit_o ? STATE_RESET : fin;
  end

endmodule

`default_nettype wire
